@@ src/aots_pkg.sv @@
// Shared types, codes and helpers for the arm, offboard and takeoff sequencer.
package aots_pkg;

	// Sequence phases.
	typedef enum logic [2:0] {
		PH_INIT     = 3'd0,
		PH_ARMING   = 3'd1,
		PH_OFFBOARD = 3'd2,
		PH_TAKEOFF  = 3'd3,
		PH_READY    = 3'd4
	} phase_t;

	// Event codes on the input stream.
	localparam logic [2:0] EV_TICK   = 3'd0;
	localparam logic [2:0] EV_STATUS = 3'd1;
	localparam logic [2:0] EV_RATE   = 3'd2;
	localparam logic [2:0] EV_TORQUE = 3'd3;
	localparam logic [2:0] EV_MOTOR  = 3'd4;
	localparam logic [2:0] EV_DISARM = 3'd5;

	// Vehicle command kinds.
	localparam logic [1:0] VC_ARM     = 2'd0;
	localparam logic [1:0] VC_DISARM  = 2'd1;
	localparam logic [1:0] VC_SETMODE = 2'd2;

	// Offboard control modes.
	localparam logic [1:0] MODE_POSITION = 2'd0;
	localparam logic [1:0] MODE_RATE     = 2'd1;
	localparam logic [1:0] MODE_TORQUE   = 2'd2;
	localparam logic [1:0] MODE_ACTUATOR = 2'd3;

	// Register indexes on the configuration channel.
	localparam logic [1:0] REG_AUTO_ARM = 2'd0;
	localparam logic [1:0] REG_HOLD_ALT = 2'd1;
	localparam logic [1:0] REG_LIVENESS = 2'd2;

	// Status codes and timing in ticks.
	localparam logic [7:0] ARMING_ARMED    = 8'd2;
	localparam logic [7:0] NAV_OFFBOARD    = 8'd14;
	localparam logic [7:0] RETRY_PERIOD    = 8'd20;
	localparam logic [7:0] ARM_TIMEOUT     = 8'd100;
	localparam logic [7:0] SETMODE_FIRST   = 8'd20;
	localparam logic [7:0] OFFBOARD_SETTLE = 8'd25;
	localparam logic [7:0] SETMODE_RETRY   = 8'd40;
	localparam logic [7:0] LONG_TIMEOUT    = 8'd200;
	localparam logic [7:0] AGE_MAX         = 8'd255;
	localparam logic [13:0] HOLD_ALT_MAX   = 14'd10000;

	// Configuration registers.
	typedef struct packed {
		logic        auto_arm_enable;
		logic [13:0] hold_altitude_mm;
		logic [7:0]  liveness_ticks;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic               vehicle_cmd_valid;
		logic [1:0]         vehicle_cmd_kind;
		logic               setpoint_valid;
		logic signed [14:0] setpoint_down_mm;
		logic               mode_valid;
		logic [1:0]         control_mode;
		logic [2:0]         sequence_state;
	} result_t;

	// True when the tick count is a whole number of retry periods.
	function automatic logic on_retry(input logic [7:0] w);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k * 20 < 256; k++) begin
			if (w == 8'(k * 20)) hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

@@ src/aots_cfg.sv @@
// Configuration register file of the sequencer.
module aots_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [13:0]       cfg_data,
	output aots_pkg::cfg_t    cfg
);

	aots_pkg::cfg_t cfg_q;

	// Writes are always taken; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_arm_enable  <= 1'b1;
			cfg_q.hold_altitude_mm <= 14'd1000;
			cfg_q.liveness_ticks   <= 8'd10;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				aots_pkg::REG_AUTO_ARM: cfg_q.auto_arm_enable  <= cfg_data[0];
				aots_pkg::REG_HOLD_ALT: cfg_q.hold_altitude_mm <= cfg_data;
				aots_pkg::REG_LIVENESS: cfg_q.liveness_ticks   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/aots_step.sv @@
// Sequence state, stream ages and the per-event result logic.
module aots_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aots_pkg::cfg_t       cfg,
	input  logic                 step_en,
	input  logic [2:0]           command,
	input  logic [7:0]           arm_status,
	input  logic [7:0]           flight_mode,
	output aots_pkg::result_t    result
);

	aots_pkg::phase_t phase_q, phase_d;
	logic [7:0] wait_q, wait_d;
	logic       armed_q, offb_q;
	logic [7:0] age_rate_q, age_torque_q, age_motor_q;

	logic       live_rate, live_torque, live_motor, live_any;
	logic       is_tick;
	logic [7:0] wait_inc;
	logic       to_takeoff;
	logic [13:0] hold_sat;

	// Stream liveness is judged from the ages before the tick.
	assign live_rate   = age_rate_q < cfg.liveness_ticks;
	assign live_torque = age_torque_q < cfg.liveness_ticks;
	assign live_motor  = age_motor_q < cfg.liveness_ticks;
	assign live_any    = live_rate | live_torque | live_motor;
	assign is_tick     = command == aots_pkg::EV_TICK;
	assign wait_inc    = wait_q + 8'd1;
	assign to_takeoff  = (wait_inc > aots_pkg::OFFBOARD_SETTLE) && offb_q;
	assign hold_sat    = (cfg.hold_altitude_mm > aots_pkg::HOLD_ALT_MAX) ?
		aots_pkg::HOLD_ALT_MAX : cfg.hold_altitude_mm;

	// Next phase and wait counter.
	always_comb begin
		phase_d = phase_q;
		wait_d  = wait_q;
		if (command == aots_pkg::EV_DISARM) begin
			phase_d = aots_pkg::PH_INIT;
			wait_d  = 8'd0;
		end else if (is_tick) begin
			unique case (phase_q)
				aots_pkg::PH_INIT: begin
					if (cfg.auto_arm_enable && live_any) begin
						phase_d = aots_pkg::PH_ARMING;
						wait_d  = 8'd0;
					end
				end
				aots_pkg::PH_ARMING: begin
					wait_d = wait_inc;
					if (armed_q) begin
						phase_d = aots_pkg::PH_OFFBOARD;
						wait_d  = 8'd0;
					end else if (wait_inc > aots_pkg::ARM_TIMEOUT) begin
						phase_d = aots_pkg::PH_INIT;
						wait_d  = 8'd0;
					end
				end
				aots_pkg::PH_OFFBOARD: begin
					wait_d = wait_inc;
					if (to_takeoff) begin
						phase_d = aots_pkg::PH_TAKEOFF;
						wait_d  = 8'd0;
					end else if (wait_inc > aots_pkg::LONG_TIMEOUT) begin
						phase_d = aots_pkg::PH_INIT;
						wait_d  = 8'd0;
					end
				end
				aots_pkg::PH_TAKEOFF: begin
					wait_d = wait_inc;
					if (wait_inc > aots_pkg::LONG_TIMEOUT) begin
						phase_d = aots_pkg::PH_READY;
						wait_d  = 8'd0;
					end
				end
				default: ;
			endcase
		end
	end

	// Result fields for the current event.
	always_comb begin
		result = '0;
		if (command == aots_pkg::EV_DISARM) begin
			result.vehicle_cmd_valid = 1'b1;
			result.vehicle_cmd_kind  = aots_pkg::VC_DISARM;
		end else if (is_tick) begin
			unique case (phase_q)
				aots_pkg::PH_INIT: begin
					if (cfg.auto_arm_enable && live_any) begin
						result.vehicle_cmd_valid = 1'b1;
						result.vehicle_cmd_kind  = aots_pkg::VC_ARM;
					end
				end
				aots_pkg::PH_ARMING: begin
					if (!armed_q && aots_pkg::on_retry(wait_inc)) begin
						result.vehicle_cmd_valid = 1'b1;
						result.vehicle_cmd_kind  = aots_pkg::VC_ARM;
					end
				end
				aots_pkg::PH_OFFBOARD: begin
					result.setpoint_valid = 1'b1;
					result.mode_valid     = 1'b1;
					if ((wait_inc == aots_pkg::SETMODE_FIRST) ||
					    ((wait_inc > aots_pkg::SETMODE_RETRY) && !offb_q &&
					     aots_pkg::on_retry(wait_inc))) begin
						result.vehicle_cmd_valid = 1'b1;
						result.vehicle_cmd_kind  = aots_pkg::VC_SETMODE;
					end
				end
				aots_pkg::PH_TAKEOFF: begin
					result.setpoint_valid = 1'b1;
					result.mode_valid     = 1'b1;
				end
				default: begin
					result.mode_valid = 1'b1;
					if (live_torque) result.control_mode = aots_pkg::MODE_TORQUE;
					else if (live_motor) result.control_mode = aots_pkg::MODE_ACTUATOR;
					else if (live_rate) result.control_mode = aots_pkg::MODE_RATE;
					else begin
						result.control_mode   = aots_pkg::MODE_POSITION;
						result.setpoint_valid = 1'b1;
					end
				end
			endcase
		end
		if (result.setpoint_valid) begin
			result.setpoint_down_mm = 15'sd0 - $signed({1'b0, hold_sat});
		end
		result.sequence_state = phase_d;
	end

	// State update when the event leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= aots_pkg::PH_INIT;
			wait_q       <= 8'd0;
			armed_q      <= 1'b0;
			offb_q       <= 1'b0;
			age_rate_q   <= 8'd0;
			age_torque_q <= 8'd0;
			age_motor_q  <= 8'd0;
		end else if (step_en) begin
			phase_q <= phase_d;
			wait_q  <= wait_d;
			case (command)
				aots_pkg::EV_TICK: begin
					if (age_rate_q != aots_pkg::AGE_MAX) age_rate_q <= age_rate_q + 8'd1;
					if (age_torque_q != aots_pkg::AGE_MAX) begin
						age_torque_q <= age_torque_q + 8'd1;
					end
					if (age_motor_q != aots_pkg::AGE_MAX) age_motor_q <= age_motor_q + 8'd1;
				end
				aots_pkg::EV_STATUS: begin
					armed_q <= arm_status == aots_pkg::ARMING_ARMED;
					offb_q  <= flight_mode == aots_pkg::NAV_OFFBOARD;
				end
				aots_pkg::EV_RATE:   age_rate_q   <= 8'd0;
				aots_pkg::EV_TORQUE: age_torque_q <= 8'd0;
				aots_pkg::EV_MOTOR:  age_motor_q  <= 8'd0;
				default: ;
			endcase
		end
	end

endmodule

@@ src/arm_offboard_takeoff_sequencer.sv @@
// Top level of the arm, offboard and takeoff sequencer.
//
// Input stream s_axis: one event per beat. tuser carries the event code
// (tick, status, rate seen, torque seen, motor seen, disarm); tdata carries
// the raw arming and navigation states used by status events.
// Output stream m_axis: exactly one result beat per input beat, in order,
// carrying the vehicle command, hold setpoint, control mode and the phase
// after the event.
// Configuration channel: cfg_valid/cfg_ready with a register index and data;
// it is always ready. It is to be written only while the stream is idle; the
// block itself does not enforce this. An event passes through the input
// register, where the sequence state is updated as it leaves, and then the
// output register. Throughput is one event per cycle while the receiver does
// not stall, as the state update between the two registers is combinational.
// When the receiver stalls, the output register holds its beat, the input
// register fills, and s_axis_tready drops until the result moves on.
// Reset clears the phase to init, the flags, counters and stream ages, and
// loads the register defaults; all streams count as live after reset.
module arm_offboard_takeoff_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] arm status, [15:8] flight mode
	input  logic [2:0]  s_axis_tuser,  // [2:0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] vehicle_cmd_valid, [2:1] vehicle_cmd_kind, [3] setpoint_valid,
	// [18:4] setpoint_down_mm, [19] mode_valid, [21:20] control_mode,
	// [24:22] sequence_state, [31:25] zero
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	aots_pkg::cfg_t    cfg;
	aots_pkg::result_t result;
	aots_pkg::result_t res_q;

	logic        vld_s1;
	logic [2:0]  command_s1;
	logic [7:0]  arming_s1, nav_s1;
	logic        out_vld_q;
	logic        advance;

	aots_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The event in the input register moves on when the output slot frees.
	assign advance       = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			command_s1 <= s_axis_tuser;
			arming_s1  <= s_axis_tdata[7:0];
			nav_s1     <= s_axis_tdata[15:8];
		end
	end

	aots_step u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.step_en      (advance),
		.command      (command_s1),
		.arm_status   (arming_s1),
		.flight_mode  (nav_s1),
		.result       (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= result;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {7'd0, res_q.sequence_state, res_q.control_mode, res_q.mode_valid,
		res_q.setpoint_down_mm, res_q.setpoint_valid, res_q.vehicle_cmd_kind,
		res_q.vehicle_cmd_valid};

endmodule

@@ tb/testbench.sv @@
// Testbench for the arm, offboard and takeoff sequencer: event streams checked against a model.
`timescale 1ns / 100ps

module testbench;
	import aots_pkg::*;

	// Event codes the block must ignore.
	localparam logic [2:0] EV_UNUSED_A = 3'd6;
	localparam logic [2:0] EV_UNUSED_B = 3'd7;
	// Register index that maps to no register.
	localparam logic [1:0] REG_UNUSED = 2'd3;
	// Length of the long receiver hold-off, in cycles.
	localparam int RX_HOLD_CYCLES = 300;

	// Tracks the sequence state and holds the result beats still due.
	class sequence_tracker;
		cfg_t       regs;
		phase_t     phase;
		logic [7:0] wait_ticks;
		bit         armed;
		bit         offboard;
		logic [7:0] rate_age;
		logic [7:0] torque_age;
		logic [7:0] motor_age;
		result_t    outputs_due[$];
		int         mismatches;

		function new();
			regs.auto_arm_enable = 1'b1;
			regs.hold_altitude_mm = 14'd1000;
			regs.liveness_ticks = 8'd10;
			phase = PH_INIT;
			wait_ticks = 8'd0;
			armed = 1'b0;
			offboard = 1'b0;
			rate_age = 8'd0;
			torque_age = 8'd0;
			motor_age = 8'd0;
			mismatches = 0;
		endfunction

		function void apply_reg(logic [1:0] idx, logic [13:0] value);
			case (idx)
				REG_AUTO_ARM: regs.auto_arm_enable = value[0];
				REG_HOLD_ALT: regs.hold_altitude_mm = value;
				REG_LIVENESS: regs.liveness_ticks = value[7:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] aged(logic [7:0] a);
			return (a == AGE_MAX) ? a : a + 8'd1;
		endfunction

		// Minus the hold altitude, clipped to the largest altitude.
		function logic [14:0] hold_down();
			logic [13:0] h;
			h = (regs.hold_altitude_mm > HOLD_ALT_MAX) ? HOLD_ALT_MAX : regs.hold_altitude_mm;
			return 15'd0 - {1'b0, h};
		endfunction

		// Advances the sequence by one accepted event and queues its result.
		function void take_event(logic [2:0] cmd, logic [7:0] arm_st, logic [7:0] nav_st);
			result_t r;
			bit live_r, live_t, live_m;
			r = '0;
			case (cmd)
				EV_TICK: begin
					// Liveness is judged on the ages before they advance.
					live_r = rate_age < regs.liveness_ticks;
					live_t = torque_age < regs.liveness_ticks;
					live_m = motor_age < regs.liveness_ticks;
					rate_age = aged(rate_age);
					torque_age = aged(torque_age);
					motor_age = aged(motor_age);
					case (phase)
						PH_INIT: begin
							if (regs.auto_arm_enable && (live_r || live_t || live_m)) begin
								r.vehicle_cmd_valid = 1'b1;
								r.vehicle_cmd_kind = VC_ARM;
								phase = PH_ARMING;
								wait_ticks = 8'd0;
							end
						end
						PH_ARMING: begin
							wait_ticks = wait_ticks + 8'd1;
							if (!armed && (wait_ticks % RETRY_PERIOD) == 8'd0) begin
								r.vehicle_cmd_valid = 1'b1;
								r.vehicle_cmd_kind = VC_ARM;
							end
							if (armed) begin
								phase = PH_OFFBOARD;
								wait_ticks = 8'd0;
							end else if (wait_ticks > ARM_TIMEOUT) begin
								phase = PH_INIT;
								wait_ticks = 8'd0;
							end
						end
						PH_OFFBOARD: begin
							r.setpoint_valid = 1'b1;
							r.mode_valid = 1'b1;
							r.control_mode = MODE_POSITION;
							wait_ticks = wait_ticks + 8'd1;
							if (wait_ticks == SETMODE_FIRST) begin
								r.vehicle_cmd_valid = 1'b1;
								r.vehicle_cmd_kind = VC_SETMODE;
							end
							if (wait_ticks > OFFBOARD_SETTLE && offboard) begin
								phase = PH_TAKEOFF;
								wait_ticks = 8'd0;
							end
							// The retry test sees the count after a possible move to takeoff.
							if (wait_ticks > SETMODE_RETRY && !offboard
								&& (wait_ticks % RETRY_PERIOD) == 8'd0) begin
								r.vehicle_cmd_valid = 1'b1;
								r.vehicle_cmd_kind = VC_SETMODE;
							end
							if (wait_ticks > LONG_TIMEOUT) begin
								phase = PH_INIT;
								wait_ticks = 8'd0;
							end
						end
						PH_TAKEOFF: begin
							r.setpoint_valid = 1'b1;
							r.mode_valid = 1'b1;
							r.control_mode = MODE_POSITION;
							wait_ticks = wait_ticks + 8'd1;
							if (wait_ticks > LONG_TIMEOUT) begin
								phase = PH_READY;
								wait_ticks = 8'd0;
							end
						end
						default: begin
							// Ready: torque wins over motor, motor over rate.
							r.mode_valid = 1'b1;
							if (live_t) r.control_mode = MODE_TORQUE;
							else if (live_m) r.control_mode = MODE_ACTUATOR;
							else if (live_r) r.control_mode = MODE_RATE;
							else begin
								r.control_mode = MODE_POSITION;
								r.setpoint_valid = 1'b1;
							end
						end
					endcase
				end
				EV_STATUS: begin
					armed = (arm_st == ARMING_ARMED);
					offboard = (nav_st == NAV_OFFBOARD);
				end
				EV_RATE: rate_age = 8'd0;
				EV_TORQUE: torque_age = 8'd0;
				EV_MOTOR: motor_age = 8'd0;
				EV_DISARM: begin
					r.vehicle_cmd_valid = 1'b1;
					r.vehicle_cmd_kind = VC_DISARM;
					phase = PH_INIT;
					wait_ticks = 8'd0;
				end
				default: ;
			endcase
			if (r.setpoint_valid) r.setpoint_down_mm = hold_down();
			r.sequence_state = phase;
			outputs_due.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			end
		endfunction

		// Compares one output beat with the oldest result still due.
		function void check_beat(logic [31:0] d);
			result_t want;
			if (outputs_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: output beat %0h with no result due", $time, d);
				return;
			end
			want = outputs_due.pop_front();
			compare_field("vehicle_cmd_valid", want.vehicle_cmd_valid, d[0]);
			compare_field("vehicle_cmd_kind", want.vehicle_cmd_kind, d[2:1]);
			compare_field("setpoint_valid", want.setpoint_valid, d[3]);
			compare_field("setpoint_down_mm", $unsigned(want.setpoint_down_mm), d[18:4]);
			compare_field("mode_valid", want.mode_valid, d[19]);
			compare_field("control_mode", want.control_mode, d[21:20]);
			compare_field("sequence_state", want.sequence_state, d[24:22]);
			compare_field("padding", 32'd0, d[31:25]);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [13:0] cfg_data = '0;

	sequence_tracker tracker;
	int tx_idle_pct = 30;
	int rx_idle_pct = 63;
	int events_sent = 0;
	bit rx_hold_req = 1'b0;
	bit rx_hold_taken = 1'b0;
	int rx_hold_left = 0;

	arm_offboard_takeoff_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: check each accepted beat, then pick tready for the next cycle.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready && tracker != null)
			tracker.check_beat(m_axis_tdata);
		if (rx_hold_req && !rx_hold_taken) begin
			rx_hold_taken <= 1'b1;
			rx_hold_left <= RX_HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Offers one event beat, with random gaps, and waits until it is taken.
	task automatic send_item(input logic [2:0] cmd, input logic [7:0] arm_st,
		input logic [7:0] nav_st);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {nav_st, arm_st};
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_event(cmd, arm_st, nav_st);
		events_sent++;
	endtask

	function automatic logic [7:0] other_than(input logic [7:0] code);
		logic [7:0] v;
		do v = 8'($urandom); while (v == code);
		return v;
	endfunction

	task automatic send_status(input bit want_armed, input bit want_offboard);
		send_item(EV_STATUS, want_armed ? ARMING_ARMED : other_than(ARMING_ARMED),
			want_offboard ? NAV_OFFBOARD : other_than(NAV_OFFBOARD));
	endtask

	task automatic send_stream_seen();
		logic [2:0] cmd;
		cmd = EV_RATE + 3'($urandom_range(2));
		send_item(cmd, 8'($urandom), 8'($urandom));
	endtask

	task automatic send_tick();
		send_item(EV_TICK, 8'($urandom), 8'($urandom));
	endtask

	task automatic send_disarm();
		send_item(EV_DISARM, 8'($urandom), 8'($urandom));
	endtask

	// A run of ticks with stream sightings mixed in.
	task automatic run_ticks(input int n, input int seen_pct);
		repeat (n) begin
			if ($urandom_range(99) < seen_pct) send_stream_seen();
			send_tick();
		end
	endtask

	task automatic send_noise(input int n);
		repeat (n) send_item(3'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Arm, offboard and takeoff run to ready, then mixed traffic; may disarm early.
	task automatic fly_sequence();
		int pick;
		send_stream_seen();
		send_tick();
		run_ticks($urandom_range(0, 45), 10);
		send_status(1'b0, $urandom_range(1));
		send_status(1'b1, 1'b0);
		send_tick();
		if ($urandom_range(9) == 0) begin
			send_disarm();
			return;
		end
		run_ticks($urandom_range(0, 45), 15);
		send_status(1'b1, 1'b1);
		run_ticks(30, 15);
		run_ticks(205, 20);
		repeat ($urandom_range(20, 60)) begin
			pick = $urandom_range(99);
			if (pick < 50) send_tick();
			else if (pick < 85) send_stream_seen();
			else if (pick < 95) send_item(EV_STATUS, 8'($urandom), 8'($urandom));
			else send_item($urandom_range(1) ? EV_UNUSED_A : EV_UNUSED_B,
				8'($urandom), 8'($urandom));
		end
		send_disarm();
	endtask

	// Arming that never sees an armed status and runs into its timeout.
	task automatic arm_timeout_run();
		send_stream_seen();
		send_tick();
		send_status(1'b0, $urandom_range(1));
		run_ticks(105, 10);
		send_disarm();
	endtask

	// Offboard switch that never sees offboard status and runs into its timeout.
	task automatic offboard_timeout_run();
		send_stream_seen();
		send_tick();
		send_status(1'b1, 1'b0);
		send_tick();
		run_ticks(205, 10);
		send_disarm();
	endtask

	// Stops offering events and waits for every result beat to come back.
	task automatic drain_outputs();
		s_axis_tvalid <= 1'b0;
		while (tracker.outputs_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [13:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		tracker.apply_reg(idx, value);
	endtask

	// Writes all registers and a stray index; unused upper bits get random values.
	task automatic configure(input logic arm_on, input logic [13:0] hold,
		input logic [7:0] live);
		write_reg(REG_AUTO_ARM, {13'($urandom), arm_on});
		write_reg(REG_HOLD_ALT, hold);
		write_reg(REG_LIVENESS, {6'($urandom), live});
		write_reg(REG_UNUSED, 14'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// One flight first, a pause for all results, then a random mix of runs.
	task automatic run_phase(input int target);
		int stop;
		int pick;
		stop = events_sent + target;
		fly_sequence();
		drain_outputs();
		while (events_sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 50) fly_sequence();
			else if (pick < 65) arm_timeout_run();
			else if (pick < 75) offboard_timeout_run();
			else send_noise($urandom_range(10, 30));
		end
	endtask

	initial begin
		#(2_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		tracker = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed events on the reset settings.
		tx_idle_pct = 30;
		rx_idle_pct = 63;
		send_item(EV_UNUSED_A, 8'hFF, 8'hFF);
		send_item(EV_UNUSED_B, 8'h00, 8'h00);
		send_tick();                         // streams live from reset: arm
		send_item(EV_STATUS, ARMING_ARMED, 8'h00);
		send_tick();                         // armed: switch to offboard
		send_tick();                         // hold setpoint in position mode
		send_item(EV_STATUS, 8'hFF, NAV_OFFBOARD);
		send_item(EV_RATE, 8'h00, 8'hFF);
		send_item(EV_TORQUE, 8'hFF, 8'h00);
		send_item(EV_MOTOR, 8'h55, 8'hAA);
		send_tick();
		send_disarm();
		send_tick();                         // re-arm from init
		send_item(EV_STATUS, 8'h00, 8'hFF);
		send_tick();
		send_item(EV_STATUS, ARMING_ARMED, NAV_OFFBOARD);
		send_tick();
		send_disarm();
		drain_outputs();

		// Full altitude, liveness only right after a sighting.
		configure(1'b1, HOLD_ALT_MAX, 8'd1);
		run_phase(300);
		drain_outputs();

		// Auto arm off and no stream ever live.
		configure(1'b0, 14'd0, 8'd0);
		send_noise(30);
		run_ticks(20, 40);
		drain_outputs();

		// Altitude above the limit, longest liveness; idling swapped.
		tx_idle_pct = 63;
		rx_idle_pct = 30;
		configure(1'b1, 14'h3FFF, 8'd255);
		run_phase(300);
		drain_outputs();

		// Zero altitude, short liveness, no idling but one long receiver hold-off.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		configure(1'b1, 14'd0, 8'($urandom_range(2, 30)));
		rx_hold_req = 1'b1;
		run_phase(300);
		drain_outputs();
		repeat (10) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.outputs_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
